// File: hdl/visual_servo_velocity_law_assert.svh
// assertion macros for the velocity law checker
`ifndef VISUAL_SERVO_VELOCITY_LAW_ASSERT_SVH
`define VISUAL_SERVO_VELOCITY_LAW_ASSERT_SVH

// same-cycle implication
`define VSVL_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vsvl assertion failed");

// next-cycle implication
`define VSVL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vsvl assertion failed");

`endif

// File: hdl/vsvl_pkg.sv
// shared types and constants of the visual servo velocity law
`timescale 1ns / 1ps
package vsvl_pkg;

    localparam int TIMEOUT_TICKS_DEF = 100;
    localparam int ALU_W             = 64;
    localparam int ALU_CNT_W         = $clog2(ALU_W);

    localparam logic [23:0] X_MAX        = 24'd8388607;
    localparam logic [15:0] LN2_Q16      = 16'd45426;
    localparam logic [19:0] DET_SCALE    = 20'd1000000;
    localparam logic [47:0] LIN_OVF_LIM  = 48'h7FFF_FFFF_FFFF;
    localparam logic [15:0] ALPHA_ONE    = 16'd32768;
    localparam logic [15:0] LIN_SAT      = 16'd32767;

    localparam logic [1:0] STATUS_DRIVE     = 2'd0;
    localparam logic [1:0] STATUS_NO_TARGET = 2'd1;
    localparam logic [1:0] STATUS_STALE     = 2'd2;
    localparam logic [1:0] STATUS_DEGEN     = 2'd3;

    localparam logic [2:0] CFG_CENTER_X   = 3'd0;
    localparam logic [2:0] CFG_FOCAL_X    = 3'd1;
    localparam logic [2:0] CFG_FOCAL_Y    = 3'd2;
    localparam logic [2:0] CFG_TARGET_H   = 3'd3;
    localparam logic [2:0] CFG_DESIRED_H  = 3'd4;
    localparam logic [2:0] CFG_GAIN       = 3'd5;
    localparam logic [2:0] CFG_ALPHA      = 3'd6;
    localparam logic [2:0] CFG_MAX_SPEED  = 3'd7;

    typedef enum logic [1:0] {
        ALU_MUL = 2'b01,
        ALU_DIV = 2'b10
    } alu_op_t;

    typedef struct packed {
        logic             start;
        alu_op_t          op;
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic             done;
        logic [ALU_W-1:0] res;
    } alu_rsp_t;

endpackage

// File: hdl/visual_servo_velocity_law.sv
// two-axis image-based visual servo velocity law, top level
// a detection with a zero height ends without using the ALU
// one item at a time, plus any wait on the output register; the work is done on the shared
// shift-add multiplier (one multiplier bit per cycle) and the 64-step restoring divider
// the log2 squarings on the tick path take most of the cycles
// reset (synchronous, active low) restores register defaults and clears target state
`timescale 1ns / 1ps
module visual_servo_velocity_law import vsvl_pkg::*; #(
    parameter int TIMEOUT_TICKS = TIMEOUT_TICKS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_req_type,
    input  logic [15:0]        s_box_center_x_q4,
    input  logic [15:0]        s_box_height_q4,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_linear_cmd,
    output logic signed [15:0] m_angular_cmd,
    output logic [1:0]         m_status
);

    // one-hot sequencer: D* detection path, T* control tick path
    typedef enum logic [25:0] {
        S_IDLE  = 26'h0000001,
        S_WAIT  = 26'h0000002,
        S_D0    = 26'h0000004,
        S_D1    = 26'h0000008,
        S_D2    = 26'h0000010,
        S_D3    = 26'h0000020,
        S_D4    = 26'h0000040,
        S_D5    = 26'h0000080,
        S_T0    = 26'h0000100,
        S_T1    = 26'h0000200,
        S_T2    = 26'h0000400,
        S_TNORM = 26'h0000800,
        S_TSQ   = 26'h0001000,
        S_TSQR  = 26'h0002000,
        S_TE2   = 26'h0004000,
        S_TE2R  = 26'h0008000,
        S_TX2   = 26'h0010000,
        S_TN    = 26'h0020000,
        S_TM1   = 26'h0040000,
        S_TR    = 26'h0080000,
        S_TC    = 26'h0100000,
        S_TL    = 26'h0200000,
        S_TTI   = 26'h0400000,
        S_TT    = 26'h0800000,
        S_TA    = 26'h1000000,
        S_DONE  = 26'h2000000
    } state_t;

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;

    // configuration registers
    logic [15:0] cx_reg, fxc_reg, fyc_reg, th_reg, hd_reg, gain_reg, alpha_reg;
    logic [14:0] vmax_reg;

    // filter and target state
    logic               seen_reg, seen_next;
    logic signed [23:0] fx_reg, fx_next;
    logic [27:0]        fh_reg, fh_next;
    logic [7:0]         ticks_reg, ticks_next;

    // latched item and working values
    logic [15:0]        req_x_reg, req_x_next;
    logic [15:0]        req_h_reg, req_h_next;
    logic               xneg_reg, xneg_next;
    logic signed [47:0] sacc_reg, sacc_next;
    logic [63:0]        tmp_reg, tmp_next;
    logic [31:0]        p_reg, p_next;
    logic [30:0]        lg_m_reg, lg_m_next;
    logic [4:0]         lg_p_reg, lg_p_next;
    logic [15:0]        lg_f_reg, lg_f_next;
    logic [3:0]         lg_i_reg, lg_i_next;
    logic               lg_sel_reg, lg_sel_next;
    logic [20:0]        l1_reg, l1_next;
    logic signed [22:0] d_reg, d_next;
    logic signed [23:0] e2_reg, e2_next;
    logic signed [23:0] k_reg, k_next;
    logic signed [48:0] n_reg, n_next;
    logic [49:0]        m1m_reg, m1m_next;
    logic               m1neg_reg, m1neg_next;
    logic               r_pass_reg, r_pass_next;
    logic [63:0]        r_reg, r_next;
    logic [15:0]        linm_reg, linm_next;
    logic               tneg_reg, tneg_next;

    // finished result, waiting for the output register
    logic signed [15:0] res_lin_reg, res_lin_next;
    logic signed [15:0] res_ang_reg, res_ang_next;
    logic [1:0]         res_st_reg, res_st_next;

    // output register
    logic               m_valid_reg, m_valid_next;
    logic signed [15:0] m_lin_reg, m_lin_next;
    logic signed [15:0] m_ang_reg, m_ang_next;
    logic [1:0]         m_st_reg, m_st_next;

    alu_req_t alu_req;
    alu_rsp_t alu_rsp;

    vsvl_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .rsp     (alu_rsp)
    );

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        logic [15:0]        a_eff, ia;
        logic [16:0]        diff;
        logic [15:0]        dmag, fxe, hde;
        logic [23:0]        xabs, kabs, qclip;
        logic signed [47:0] s2, ssum;
        logic [47:0]        smag;
        logic [63:0]        w;
        logic [7:0]         tick_inc;
        logic [32:0]        mm;
        logic [15:0]        f_new;
        logic [20:0]        lval;
        logic [21:0]        dabs;
        logic [23:0]        e2m;
        logic [48:0]        nabs;
        logic [15:0]        lin_c, ang_c;
        logic [27:0]        am;

        state_next   = state_reg;
        ret_next     = ret_reg;
        seen_next    = seen_reg;
        fx_next      = fx_reg;
        fh_next      = fh_reg;
        ticks_next   = ticks_reg;
        req_x_next   = req_x_reg;
        req_h_next   = req_h_reg;
        xneg_next    = xneg_reg;
        sacc_next    = sacc_reg;
        tmp_next     = tmp_reg;
        p_next       = p_reg;
        lg_m_next    = lg_m_reg;
        lg_p_next    = lg_p_reg;
        lg_f_next    = lg_f_reg;
        lg_i_next    = lg_i_reg;
        lg_sel_next  = lg_sel_reg;
        l1_next      = l1_reg;
        d_next       = d_reg;
        e2_next      = e2_reg;
        k_next       = k_reg;
        n_next       = n_reg;
        m1m_next     = m1m_reg;
        m1neg_next   = m1neg_reg;
        r_pass_next  = r_pass_reg;
        r_next       = r_reg;
        linm_next    = linm_reg;
        tneg_next    = tneg_reg;
        res_lin_next = res_lin_reg;
        res_ang_next = res_ang_reg;
        res_st_next  = res_st_reg;
        m_valid_next = m_valid_reg;
        m_lin_next   = m_lin_reg;
        m_ang_next   = m_ang_reg;
        m_st_next    = m_st_reg;
        alu_req      = '{start: 1'b0, op: ALU_MUL, a: '0, b: '0};

        // alpha above one acts as one
        a_eff = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;
        ia    = ALPHA_ONE - a_eff;
        diff  = {1'b0, req_x_reg} - {1'b0, cx_reg};
        dmag  = diff[16] ? 16'(-diff) : diff[15:0];
        fxe   = (fxc_reg == '0) ? 16'd1 : fxc_reg;
        hde   = (hd_reg == '0) ? 16'd1 : hd_reg;
        xabs  = fx_reg[23] ? 24'(-fx_reg) : 24'(fx_reg);
        kabs  = k_reg[23] ? 24'(-k_reg) : 24'(k_reg);
        qclip = (alu_rsp.res > 64'(X_MAX)) ? X_MAX : alu_rsp.res[23:0];
        s2    = fx_reg[23] ? -48'(signed'(alu_rsp.res[47:0])) : 48'(signed'(alu_rsp.res[47:0]));
        ssum  = sacc_reg + s2;
        smag  = ssum[47] ? 48'(-ssum) : 48'(ssum);
        w     = '0;
        tick_inc = (ticks_reg == 8'hFF) ? ticks_reg : ticks_reg + 8'd1;
        mm    = alu_rsp.res[62:30];
        f_new = mm[31] ? (lg_f_reg | (16'h8000 >> lg_i_reg)) : lg_f_reg;
        lval  = {lg_p_reg, f_new};
        dabs  = d_reg[22] ? 22'(-d_reg) : 22'(d_reg);
        e2m   = '0;
        nabs  = n_reg[48] ? 49'(-n_reg) : 49'(n_reg);
        lin_c = (linm_reg > {1'b0, vmax_reg}) ? {1'b0, vmax_reg} : linm_reg;
        am    = '0;
        ang_c = '0;

        // output register drains independently of the sequencer
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    req_x_next = s_box_center_x_q4;
                    req_h_next = s_box_height_q4;
                    state_next = s_req_type ? S_T0 : S_D0;
                end
            end
            S_WAIT: begin
                if (alu_rsp.done) begin
                    state_next = ret_reg;
                end
            end

            // detection: x = (u - cx) * 2048 / fx, rounded
            S_D0: begin
                if (req_h_reg == '0) begin
                    state_next = S_IDLE;
                end else begin
                    xneg_next  = diff[16];
                    alu_req    = '{start: 1'b1, op: ALU_DIV,
                                   a: 64'({dmag, 11'b0}) + 64'(fxe >> 1), b: 64'(fxe)};
                    ret_next   = S_D1;
                    state_next = S_WAIT;
                end
            end
            S_D1: begin
                if (!seen_reg) begin
                    // first detection seeds the filter
                    fx_next    = xneg_reg ? 24'(-qclip) : qclip;
                    fh_next    = {req_h_reg, 12'b0};
                    seen_next  = 1'b1;
                    ticks_next = '0;
                    state_next = S_IDLE;
                end else begin
                    alu_req    = '{start: 1'b1, op: ALU_MUL, a: 64'(a_eff), b: 64'(qclip)};
                    ret_next   = S_D2;
                    state_next = S_WAIT;
                end
            end
            S_D2: begin
                sacc_next  = xneg_reg ? -48'(signed'(alu_rsp.res[47:0]))
                                      : 48'(signed'(alu_rsp.res[47:0]));
                alu_req    = '{start: 1'b1, op: ALU_MUL, a: 64'(ia), b: 64'(xabs)};
                ret_next   = S_D3;
                state_next = S_WAIT;
            end
            S_D3: begin
                w          = 64'(smag) + 64'd16384;
                fx_next    = ssum[47] ? -24'(signed'(w[38:15])) : 24'(signed'(w[38:15]));
                alu_req    = '{start: 1'b1, op: ALU_MUL, a: 64'(a_eff),
                               b: 64'({req_h_reg, 12'b0})};
                ret_next   = S_D4;
                state_next = S_WAIT;
            end
            S_D4: begin
                tmp_next   = alu_rsp.res;
                alu_req    = '{start: 1'b1, op: ALU_MUL, a: 64'(ia), b: 64'(fh_reg)};
                ret_next   = S_D5;
                state_next = S_WAIT;
            end
            S_D5: begin
                w          = tmp_reg + alu_rsp.res + 64'd16384;
                fh_next    = w[42:15];
                seen_next  = 1'b1;
                ticks_next = '0;
                state_next = S_IDLE;
            end

            // control tick: age the target, then status checks
            S_T0: begin
                ticks_next   = tick_inc;
                res_lin_next = '0;
                res_ang_next = '0;
                if (!seen_reg) begin
                    res_st_next = STATUS_NO_TARGET;
                    state_next  = S_DONE;
                end else if (tick_inc > 8'(TIMEOUT_TICKS)) begin
                    res_st_next = STATUS_STALE;
                    state_next  = S_DONE;
                end else begin
                    alu_req    = '{start: 1'b1, op: ALU_MUL, a: 64'(fyc_reg), b: 64'(th_reg)};
                    ret_next   = S_T1;
                    state_next = S_WAIT;
                end
            end
            S_T1: begin
                p_next     = alu_rsp.res[31:0];
                alu_req    = '{start: 1'b1, op: ALU_MUL, a: 64'(fh_reg), b: 64'(DET_SCALE)};
                ret_next   = S_T2;
                state_next = S_WAIT;
            end
            S_T2: begin
                // determinant below 1e-6 or a zero factor
                if (fh_reg == '0 || fxc_reg == '0 || fyc_reg == '0 || th_reg == '0 ||
                    alu_rsp.res < 64'(p_reg)) begin
                    res_st_next = STATUS_DEGEN;
                    state_next  = S_DONE;
                end else begin
                    lg_m_next   = 31'(fh_reg);
                    lg_p_next   = 5'd30;
                    lg_sel_next = 1'b0;
                    state_next  = S_TNORM;
                end
            end

            // log2 in q16: normalize one bit a cycle, then 16 squarings
            S_TNORM: begin
                if (lg_m_reg[30]) begin
                    lg_f_next  = '0;
                    lg_i_next  = '0;
                    state_next = S_TSQ;
                end else begin
                    lg_m_next = {lg_m_reg[29:0], 1'b0};
                    lg_p_next = lg_p_reg - 5'd1;
                end
            end
            S_TSQ: begin
                alu_req    = '{start: 1'b1, op: ALU_MUL, a: 64'(lg_m_reg), b: 64'(lg_m_reg)};
                ret_next   = S_TSQR;
                state_next = S_WAIT;
            end
            S_TSQR: begin
                lg_m_next = mm[31] ? mm[31:1] : mm[30:0];
                lg_f_next = f_new;
                lg_i_next = lg_i_reg + 4'd1;
                if (lg_i_reg == 4'd15) begin
                    if (!lg_sel_reg) begin
                        l1_next     = lval;
                        lg_m_next   = {3'b0, hde, 12'b0};
                        lg_p_next   = 5'd30;
                        lg_sel_next = 1'b1;
                        state_next  = S_TNORM;
                    end else begin
                        d_next     = 23'(signed'({2'b0, l1_reg})) - 23'(signed'({2'b0, lval}));
                        state_next = S_TE2;
                    end
                end else begin
                    state_next = S_TSQ;
                end
            end

            // e2 = ln h - ln h_des, k = 1 - e2
            S_TE2: begin
                alu_req    = '{start: 1'b1, op: ALU_MUL, a: 64'(dabs), b: 64'(LN2_Q16)};
                ret_next   = S_TE2R;
                state_next = S_WAIT;
            end
            S_TE2R: begin
                w          = alu_rsp.res + 64'd32768;
                e2m        = w[39:16];
                e2_next    = d_reg[22] ? -24'(signed'(e2m)) : 24'(signed'(e2m));
                k_next     = 24'sd65536 - (d_reg[22] ? -24'(signed'(e2m)) : 24'(signed'(e2m)));
                alu_req    = '{start: 1'b1, op: ALU_MUL, a: 64'(xabs), b: 64'(xabs)};
                ret_next   = S_TX2;
                state_next = S_WAIT;
            end
            S_TX2: begin
                w          = alu_rsp.res + 64'd32;
                alu_req    = '{start: 1'b1, op: ALU_MUL, a: 64'(w[46:6]), b: 64'(kabs)};
                ret_next   = S_TN;
                state_next = S_WAIT;
            end
            S_TN: begin
                w          = alu_rsp.res + 64'd32768;
                n_next     = (k_reg[23] ? -49'(signed'({1'b0, w[63:16]}))
                                        : 49'(signed'({1'b0, w[63:16]})))
                             - 49'(e2_reg);
                state_next = S_TM1;
            end
            S_TM1: begin
                alu_req     = '{start: 1'b1, op: ALU_MUL, a: 64'(nabs), b: 64'(gain_reg)};
                m1neg_next  = n_reg[48];
                r_pass_next = 1'b0;
                ret_next    = S_TR;
                state_next  = S_WAIT;
            end

            // R = fy * H / h in q24, then the overflow guard on m1 * R
            // first pass takes m1, second pass takes R
            S_TR: begin
                w = alu_rsp.res + 64'd16384;
                if (r_pass_reg) begin
                    r_next = alu_rsp.res;
                    if (alu_rsp.res == '0) begin
                        linm_next  = '0;
                        state_next = S_TTI;
                    end else begin
                        alu_req    = '{start: 1'b1, op: ALU_DIV, a: 64'(LIN_OVF_LIM),
                                       b: alu_rsp.res};
                        ret_next   = S_TC;
                        state_next = S_WAIT;
                    end
                end else begin
                    m1m_next    = w[64-1:15];
                    r_pass_next = 1'b1;
                    alu_req     = '{start: 1'b1, op: ALU_DIV,
                                    a: {p_reg, 24'b0} + 64'(fh_reg >> 1), b: 64'(fh_reg)};
                    ret_next    = S_TR;
                    state_next  = S_WAIT;
                end
            end
            S_TC: begin
                if (64'(m1m_reg) > alu_rsp.res) begin
                    linm_next  = LIN_SAT;
                    state_next = S_TTI;
                end else begin
                    alu_req    = '{start: 1'b1, op: ALU_MUL, a: 64'(m1m_reg), b: r_reg};
                    ret_next   = S_TL;
                    state_next = S_WAIT;
                end
            end
            S_TL: begin
                w          = alu_rsp.res + 64'h8000_0000;
                linm_next  = w[47:32];
                state_next = S_TTI;
            end

            // angular = gain * x * k
            S_TTI: begin
                alu_req    = '{start: 1'b1, op: ALU_MUL, a: 64'(xabs), b: 64'(kabs)};
                ret_next   = S_TT;
                state_next = S_WAIT;
            end
            S_TT: begin
                w          = alu_rsp.res + 64'd1024;
                tneg_next  = fx_reg[23] ^ k_reg[23];
                alu_req    = '{start: 1'b1, op: ALU_MUL, a: 64'(w[45:11]), b: 64'(gain_reg)};
                ret_next   = S_TA;
                state_next = S_WAIT;
            end
            S_TA: begin
                w            = alu_rsp.res + 64'h40_0000;
                am           = w[50:23];
                ang_c        = (am > 28'(vmax_reg)) ? {1'b0, vmax_reg} : am[15:0];
                res_ang_next = tneg_reg ? 16'(-ang_c) : ang_c;
                res_lin_next = m1neg_reg ? 16'(-lin_c) : lin_c;
                res_st_next  = STATUS_DRIVE;
                state_next   = S_DONE;
            end

            // hand the item to the output register once it is free
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_lin_next   = res_lin_reg;
                    m_ang_next   = res_ang_reg;
                    m_st_next    = res_st_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            ret_reg     <= S_IDLE;
            seen_reg    <= 1'b0;
            fx_reg      <= '0;
            fh_reg      <= '0;
            ticks_reg   <= '0;
            m_valid_reg <= 1'b0;
            cx_reg      <= 16'd5120;
            fxc_reg     <= 16'd9600;
            fyc_reg     <= 16'd9600;
            th_reg      <= 16'd2580;
            hd_reg      <= 16'd2400;
            gain_reg    <= 16'd16384;
            alpha_reg   <= 16'd13107;
            vmax_reg    <= 15'd2560;
        end else begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            seen_reg    <= seen_next;
            fx_reg      <= fx_next;
            fh_reg      <= fh_next;
            ticks_reg   <= ticks_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                case (cfg_index)
                    CFG_CENTER_X:  cx_reg    <= cfg_data;
                    CFG_FOCAL_X:   fxc_reg   <= cfg_data;
                    CFG_FOCAL_Y:   fyc_reg   <= cfg_data;
                    CFG_TARGET_H:  th_reg    <= cfg_data;
                    CFG_DESIRED_H: hd_reg    <= cfg_data;
                    CFG_GAIN:      gain_reg  <= cfg_data;
                    CFG_ALPHA:     alpha_reg <= cfg_data;
                    CFG_MAX_SPEED: vmax_reg  <= cfg_data[14:0];
                    default: ;
                endcase
            end
        end
        req_x_reg   <= req_x_next;
        req_h_reg   <= req_h_next;
        xneg_reg    <= xneg_next;
        sacc_reg    <= sacc_next;
        tmp_reg     <= tmp_next;
        p_reg       <= p_next;
        lg_m_reg    <= lg_m_next;
        lg_p_reg    <= lg_p_next;
        lg_f_reg    <= lg_f_next;
        lg_i_reg    <= lg_i_next;
        lg_sel_reg  <= lg_sel_next;
        l1_reg      <= l1_next;
        d_reg       <= d_next;
        e2_reg      <= e2_next;
        k_reg       <= k_next;
        n_reg       <= n_next;
        m1m_reg     <= m1m_next;
        m1neg_reg   <= m1neg_next;
        r_pass_reg  <= r_pass_next;
        r_reg       <= r_next;
        linm_reg    <= linm_next;
        tneg_reg    <= tneg_next;
        res_lin_reg <= res_lin_next;
        res_ang_reg <= res_ang_next;
        res_st_reg  <= res_st_next;
        m_lin_reg   <= m_lin_next;
        m_ang_reg   <= m_ang_next;
        m_st_reg    <= m_st_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_linear_cmd  = m_lin_reg;
    assign m_angular_cmd = m_ang_reg;
    assign m_status      = m_st_reg;

endmodule

// File: hdl/vsvl_alu.sv
// shared shift-add multiplier and restoring divider
`timescale 1ns / 1ps
module vsvl_alu import vsvl_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    alu_op_t              op_reg, op_next;
    logic [ALU_W-1:0]     a_reg, a_next;
    logic [ALU_W-1:0]     b_reg, b_next;
    logic [ALU_W-1:0]     acc_reg, acc_next;
    logic [ALU_CNT_W-1:0] cnt_reg, cnt_next;

    always_comb begin
        logic [ALU_W-1:0] rem;
        logic             qbit;
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        rem       = {acc_reg[ALU_W-2:0], a_reg[ALU_W-1]};
        qbit      = 1'b0;
        if (req.start) begin
            busy_next = 1'b1;
            op_next   = req.op;
            a_next    = req.a;
            b_next    = req.b;
            acc_next  = '0;
            cnt_next  = '0;
        end else if (busy_reg) begin
            case (op_reg)
                ALU_MUL: begin
                    if (b_reg == '0) begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end else begin
                        if (b_reg[0]) begin
                            acc_next = acc_reg + a_reg;
                        end
                        a_next = {a_reg[ALU_W-2:0], 1'b0};
                        b_next = {1'b0, b_reg[ALU_W-1:1]};
                    end
                end
                ALU_DIV: begin
                    if (rem >= b_reg) begin
                        acc_next = rem - b_reg;
                        qbit     = 1'b1;
                    end else begin
                        acc_next = rem;
                    end
                    a_next   = {a_reg[ALU_W-2:0], qbit};
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == ALU_CNT_W'(ALU_W - 1)) begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                end
                default: begin
                    busy_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= ALU_MUL;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
        end
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
        cnt_reg <= cnt_next;
    end

    assign rsp.done = done_reg;
    assign rsp.res  = (op_reg == ALU_DIV) ? a_reg : acc_reg;

endmodule

// File: hdl/vsvl_checker.sv
// port-level checker for the velocity law, bound to the top level
`timescale 1ns / 1ps
`include "visual_servo_velocity_law_assert.svh"
module vsvl_checker import vsvl_pkg::*; (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               s_req_type,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [15:0] m_linear_cmd,
    input logic signed [15:0] m_angular_cmd,
    input logic [1:0]         m_status
);

    // a stalled result holds
    `VSVL_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_linear_cmd) && $stable(m_angular_cmd) && $stable(m_status))
    // any non-driving status carries zero commands
    `VSVL_ASSERT_NOW(a_idle_zero, aclk, aresetn, m_valid && m_status != STATUS_DRIVE, m_linear_cmd == 16'sd0 && m_angular_cmd == 16'sd0)
    // the sequencer is busy right after taking an item
    `VSVL_ASSERT_NEXT(a_busy_after, aclk, aresetn, s_valid && s_ready, !s_ready)
    // a detection never raises a result on its own
    `VSVL_ASSERT_NEXT(a_det_silent, aclk, aresetn, s_valid && s_ready && !s_req_type && !m_valid, !m_valid)

endmodule

bind visual_servo_velocity_law vsvl_checker u_vsvl_checker (.*);
